/* rtl/core/qed_pkg.sv */
package qed_pkg;

    // Input request kinds carried on the slave tuser
    typedef enum logic [1:0] {
        FUNC_EDGE  = 2'd0,
        FUNC_CLEAR = 2'd1,
        FUNC_LOAD  = 2'd2
    } func_t;

    // Step direction codes on the master tuser
    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd2;

    // Pin state codes, A in bit 1 and B in bit 0
    localparam logic [1:0] PINS_00 = 2'b00;
    localparam logic [1:0] PINS_01 = 2'b01;
    localparam logic [1:0] PINS_10 = 2'b10;
    localparam logic [1:0] PINS_11 = 2'b11;

    localparam int PPR_W     = 16;
    localparam int TURN_W    = 18;
    localparam int DEG_W     = 18;
    localparam int PROD_W    = 34;        // |turn| * 46080 magnitude
    localparam int DIV_STEPS = PROD_W / 2; // two quotient bits per cycle
    localparam int ITER_W    = $clog2(DIV_STEPS);

    localparam logic [PPR_W-1:0]  PPR_RESET  = 16'd500;
    localparam logic [15:0]       DEG_SCALE  = 16'd46080;   // 360 * 128
    localparam logic [PROD_W-1:0] DEG_LIMIT  = 34'd92159;
    localparam int                TURN_LIMIT = 131069;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;    // apply the input request to the counters
        logic mul_en;    // form |angle| * scale into the divider
        logic div_step;  // one radix-4 division step
        logic out_load;  // move the result into the output register
    } cmd_t;

    // Top level to controller status
    typedef struct packed {
        logic out_free;  // output register empty or being drained
    } stat_t;

    typedef struct packed {
        logic [1:0]        step_dir;
        logic [DEG_W-1:0]  angle_deg_q8;
        logic [31:0]       rev_count;
        logic [TURN_W-1:0] angle_count;
        logic [31:0]       pulse_count;
    } res_t;

endpackage

/* rtl/core/quadrature_edge_decoder.sv */
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tuser: func; tdata: chan_a, chan_b, load_pulses, load_revs
// m_*       out  m_tvalid/m_tready  tuser: step_dir; tdata: pulse, angle, rev, angle_deg_q8
// cfg_*     in   cfg_we             cfg_wdata: pulses_per_rev
//
// Each request passes from acceptance to a loaded output register through a
// counter update, the angle multiply, 17 radix-4 steps of the serial divider
// (angle * 46080 / pulses_per_rev) and the load of the output register.
// A new request is taken while the previous result still waits in the output
// register; the controller only stalls at its final step while that is full.
// Reset (rst_n, async, active low) clears all counts, pin history and output
// valid, and sets pulses_per_rev to 500.
module quadrature_edge_decoder
    import qed_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
)
(
    input  logic          clk,
    input  logic          rst_n,
    // slave side request
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [71:0]   s_tdata,    // [0] chan_a, [1] chan_b, [33:2] load_pulses,
                                      // [65:34] load_revs, [71:66] zero
    input  logic [1:0]    s_tuser,    // [1:0] func
    // master side result
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [103:0]  m_tdata,    // [31:0] pulse_count, [49:32] angle_count,
                                      // [81:50] rev_count, [99:82] angle_deg_q8, [103:100] zero
    output logic [1:0]    m_tuser,    // [1:0] step_dir
    // configuration
    input  logic          cfg_we,
    input  logic [15:0]   cfg_wdata   // pulses_per_rev
);

    cmd_t   cmd;
    stat_t  stat;
    res_t   res;

    logic          m_tvalid_reg;
    logic [103:0]  m_tdata_reg;
    logic [1:0]    m_tuser_reg;

    // output register is free when empty or being taken this cycle
    assign stat.out_free = !m_tvalid_reg || m_tready;

    qed_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    qed_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .func        (s_tuser),
        .chan_a      (s_tdata[0]),
        .chan_b      (s_tdata[1]),
        .load_pulses ($signed(s_tdata[33:2])),
        .load_revs   ($signed(s_tdata[65:34])),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .res         (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (cmd.out_load)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            m_tdata_reg <= {4'b0000, res.angle_deg_q8, res.rev_count,
                            res.angle_count, res.pulse_count};
            m_tuser_reg <= res.step_dir;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !m_tvalid_reg || m_tready)
        else $error("result overwrote a pending output");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> m_tvalid_reg)
        else $error("loaded result not presented");

    a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken during computation");

endmodule

/* rtl/core/qed_ctrl.sv */
module qed_ctrl
    import qed_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t              state_reg, state_next;
    logic [ITER_W-1:0]   iter_reg, iter_next;
    logic                iter_last;

    assign iter_last = (iter_reg == ITER_W'(DIV_STEPS - 1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_MUL;
            ST_MUL:  state_next = ST_DIV;
            ST_DIV:  if (iter_last) state_next = ST_OUT;
            ST_OUT:  if (stat.out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cmd          = '0;
        iter_next    = iter_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_MUL:
            begin
                cmd.mul_en = 1'b1;
                iter_next  = '0;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                iter_next    = iter_reg + ITER_W'(1);
            end
            ST_OUT:  cmd.out_load = stat.out_free;
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            iter_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
        end
    end

    a_accept_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> state_reg == ST_MUL)
        else $error("accepted request did not start the multiply");

    a_mul_to_div: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MUL |=> state_reg == ST_DIV && iter_reg == '0)
        else $error("division did not start at step zero");

    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_OUT && !stat.out_free |=> state_reg == ST_OUT)
        else $error("result dropped while output register busy");

endmodule

/* rtl/core/qed_datapath.sv */
module qed_datapath
    import qed_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    input  logic [1:0]         func,
    input  logic               chan_a,
    input  logic               chan_b,
    input  logic signed [31:0] load_pulses,
    input  logic signed [31:0] load_revs,
    input  logic               cfg_we,
    input  logic [PPR_W-1:0]   cfg_wdata,
    output res_t               res
);

    logic [PPR_W-1:0]              ppr_reg;
    logic [1:0]                    prev_reg, prev_next;
    logic signed [COUNT_WIDTH-1:0] total_reg, total_next;
    logic signed [COUNT_WIDTH-1:0] rev_reg, rev_next;
    logic signed [TURN_W-1:0]      turn_reg, turn_next;
    logic [1:0]                    dir_reg, dir_next;

    logic [PROD_W-1:0]             quo_reg;
    logic [PPR_W-1:0]              rem_reg;
    logic                          neg_reg;

    logic [PPR_W-1:0]              ppr_eff;
    logic [1:0]                    cur_pins;
    logic                          step_up, step_dn;
    logic signed [TURN_W:0]        turn_step, two_ppr;
    logic [63:0]                   lp_ext, lr_ext;
    logic [TURN_W-1:0]             turn_abs;

    logic [PPR_W:0]                r1, r2;
    logic [PPR_W-1:0]              r1_red;
    logic                          q1, q2;
    logic [DEG_W-2:0]              deg_mag;
    logic signed [63:0]            total_ext, rev_ext;

    assign ppr_eff  = (ppr_reg == '0) ? PPR_W'(1) : ppr_reg;
    assign cur_pins = {chan_a, chan_b};
    assign step_up  = (prev_reg == PINS_11 && cur_pins == PINS_00) ||
                      (prev_reg == PINS_00 && cur_pins == PINS_11);
    assign step_dn  = (prev_reg == PINS_10 && cur_pins == PINS_01) ||
                      (prev_reg == PINS_01 && cur_pins == PINS_10);
    assign two_ppr  = $signed({2'b00, ppr_eff, 1'b0});
    assign lp_ext   = 64'(load_pulses);
    assign lr_ext   = 64'(load_revs);

    always_comb
    begin
        if (step_up)
            turn_step = (TURN_W+1)'(turn_reg) + (TURN_W+1)'(1);
        else if (step_dn)
            turn_step = (TURN_W+1)'(turn_reg) - (TURN_W+1)'(1);
        else
            turn_step = (TURN_W+1)'(turn_reg);
    end

    always_comb
    begin
        prev_next  = prev_reg;
        total_next = total_reg;
        rev_next   = rev_reg;
        turn_next  = turn_reg;
        dir_next   = DIR_NONE;
        case (func_t'(func))
            FUNC_EDGE:
            begin
                prev_next = cur_pins;
                if (step_up)
                begin
                    total_next = total_reg + COUNT_WIDTH'(1);
                    dir_next   = DIR_UP;
                end
                else if (step_dn)
                begin
                    total_next = total_reg - COUNT_WIDTH'(1);
                    dir_next   = DIR_DOWN;
                end
                // wrap test runs even when no count was taken
                if (turn_step >= two_ppr)
                begin
                    turn_next = '0;
                    rev_next  = rev_reg + COUNT_WIDTH'(1);
                end
                else if (turn_step <= -two_ppr)
                begin
                    turn_next = '0;
                    rev_next  = rev_reg - COUNT_WIDTH'(1);
                end
                else
                    turn_next = turn_step[TURN_W-1:0];
            end
            FUNC_CLEAR:
            begin
                total_next = '0;
                rev_next   = '0;
                turn_next  = '0;
            end
            FUNC_LOAD:
            begin
                total_next = lp_ext[COUNT_WIDTH-1:0];
                rev_next   = lr_ext[COUNT_WIDTH-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ppr_reg   <= PPR_RESET;
            prev_reg  <= '0;
            total_reg <= '0;
            rev_reg   <= '0;
            turn_reg  <= '0;
            dir_reg   <= DIR_NONE;
        end
        else
        begin
            if (cfg_we)
                ppr_reg <= cfg_wdata;
            if (cmd.accept)
            begin
                prev_reg  <= prev_next;
                total_reg <= total_next;
                rev_reg   <= rev_next;
                turn_reg  <= turn_next;
                dir_reg   <= dir_next;
            end
        end
    end

    // Divider: |turn|*46080 / ppr, restoring, two quotient bits per step.
    // quo_reg shifts the dividend out at the top and the quotient in below.
    assign turn_abs = turn_reg[TURN_W-1] ? TURN_W'(-turn_reg) : TURN_W'(turn_reg);

    always_comb
    begin
        r1     = {rem_reg, quo_reg[PROD_W-1]};
        q1     = (r1 >= {1'b0, ppr_eff});
        r1_red = q1 ? PPR_W'(r1 - {1'b0, ppr_eff}) : r1[PPR_W-1:0];
        r2     = {r1_red, quo_reg[PROD_W-2]};
        q2     = (r2 >= {1'b0, ppr_eff});
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            quo_reg <= PROD_W'(turn_abs * DEG_SCALE);
            rem_reg <= '0;
            neg_reg <= turn_reg[TURN_W-1];
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[PROD_W-3:0], q1, q2};
            rem_reg <= q2 ? PPR_W'(r2 - {1'b0, ppr_eff}) : r2[PPR_W-1:0];
        end
    end

    assign deg_mag   = (quo_reg > DEG_LIMIT) ? DEG_LIMIT[DEG_W-2:0] : quo_reg[DEG_W-2:0];
    assign total_ext = 64'(total_reg);
    assign rev_ext   = 64'(rev_reg);

    always_comb
    begin
        res.pulse_count  = total_ext[31:0];
        res.angle_count  = turn_reg;
        res.rev_count    = rev_ext[31:0];
        res.angle_deg_q8 = neg_reg ? -{1'b0, deg_mag} : {1'b0, deg_mag};
        res.step_dir     = dir_reg;
    end

    a_turn_bound: assert property (@(posedge clk) disable iff (!rst_n)
        turn_reg <= TURN_W'(TURN_LIMIT) && turn_reg >= -TURN_W'(TURN_LIMIT))
        else $error("angle count out of range");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept && func == FUNC_CLEAR |=>
            turn_reg == '0 && total_reg == '0 && rev_reg == '0)
        else $error("clear left a count standing");

endmodule
